[rtl/core/address_range_table_core_assert.svh]
// ----------------------------------------------------------------------------
// address_range_table_core_assert
// Assertion macros shared by the address range table RTL. Each macro expects
// clk and rst_n to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RANGE_TABLE_CORE_ASSERT_SVH
`define ADDRESS_RANGE_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ART_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("address range table assertion failed");

// Next-cycle implication, checked out of reset.
`define ART_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("address range table assertion failed");

`endif

[rtl/core/art_pkg.sv]
// ----------------------------------------------------------------------------
// art_pkg
// Shared sizes, command and status codes, and transaction types for the
// address range table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package art_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int ADDR_BITS   = 48;
  localparam int TAG_BITS    = 16;
  localparam int IDX_BITS    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  // Command codes
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_SEARCH  = 2'd1;
  localparam logic [1:0] CMD_OVERLAP = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BUSY      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  typedef struct packed {
    logic [1:0] cmd;
    addr_t      lo_addr;
    addr_t      hi_addr;
    tag_t       tag_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       hit;
    tag_t       tag_out;
    addr_t      match_lo;
    addr_t      match_hi;
  } out_item_t;

  // Table write request from the match logic
  typedef struct packed {
    logic  en;
    idx_t  slot;
    addr_t lo;
    addr_t hi;
    tag_t  tag;
  } tbl_wr_t;

endpackage

`default_nettype wire

[rtl/core/art_table.sv]
// ----------------------------------------------------------------------------
// art_table
// Register-held range table: valid bits, range bounds, tags, and a pairwise
// start-order matrix kept up to date on every insert.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module art_table
  import art_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire tbl_wr_t                wr,
  output logic [NUM_ENTRIES-1:0]      valid,
  output addr_t                       lo   [NUM_ENTRIES],
  output addr_t                       hi   [NUM_ENTRIES],
  output tag_t                        tag  [NUM_ENTRIES],
  output logic [NUM_ENTRIES-1:0]      less [NUM_ENTRIES]
);

  logic [NUM_ENTRIES-1:0] valid_r;
  addr_t                  lo_r   [NUM_ENTRIES];
  addr_t                  hi_r   [NUM_ENTRIES];
  tag_t                   tag_r  [NUM_ENTRIES];
  // less_r[i][j]: start of entry i is below start of entry j
  logic [NUM_ENTRIES-1:0] less_r [NUM_ENTRIES];

  logic [NUM_ENTRIES-1:0] new_below;   // new start below entry j
  logic [NUM_ENTRIES-1:0] new_above;   // entry j start below new start

  // Compare the incoming start against every stored start
  always_comb begin
    for (int j = 0; j < NUM_ENTRIES; j++) begin
      new_below[j] = wr.lo < lo_r[j];
      new_above[j] = lo_r[j] < wr.lo;
    end
  end

  // Hold valid bits across reset-free payload storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.slot] <= 1'b1;
    end
  end

  // Write bounds, tag and the order row and column of the new slot
  always_ff @(posedge clk) begin
    if (wr.en) begin
      lo_r[wr.slot]   <= wr.lo;
      hi_r[wr.slot]   <= wr.hi;
      tag_r[wr.slot]  <= wr.tag;
      less_r[wr.slot] <= new_below;
      for (int j = 0; j < NUM_ENTRIES; j++) begin
        if (idx_t'(j) != wr.slot) begin
          less_r[j][wr.slot] <= new_above[j];
        end
      end
    end
  end

  assign valid = valid_r;
  assign lo    = lo_r;
  assign hi    = hi_r;
  assign tag   = tag_r;
  assign less  = less_r;

endmodule

`default_nettype wire

[rtl/core/art_match.sv]
// ----------------------------------------------------------------------------
// art_match
// Single-pass command logic: parallel containment and overlap compares on
// every entry, lowest-start selection from the order matrix, free-slot pick,
// and result formation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module art_match
  import art_pkg::*;
(
  input  wire in_item_t               item,
  input  wire logic [NUM_ENTRIES-1:0] valid,
  input  wire addr_t                  lo   [NUM_ENTRIES],
  input  wire addr_t                  hi   [NUM_ENTRIES],
  input  wire tag_t                   tag  [NUM_ENTRIES],
  input  wire logic [NUM_ENTRIES-1:0] less [NUM_ENTRIES],
  output out_item_t                   result,
  output tbl_wr_t                     wr_req
);

  logic [NUM_ENTRIES-1:0] contain;
  logic [NUM_ENTRIES-1:0] overlap;
  logic [NUM_ENTRIES-1:0] above;
  logic [NUM_ENTRIES-1:0] lowest_ok;
  logic [NUM_ENTRIES-1:0] sel;
  logic                   is_lowest;
  idx_t                   free_slot;
  tag_t                   sel_tag;
  addr_t                  sel_lo;
  addr_t                  sel_hi;

  // Compare the query against every entry in parallel
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      contain[i] = valid[i] && (lo[i] <= item.lo_addr) && (item.lo_addr <= hi[i]);
      overlap[i] = valid[i] && (item.hi_addr >= lo[i]) && (hi[i] >= item.lo_addr);
      above[i]   = valid[i] && (lo[i] > item.lo_addr);
    end
  end

  // Pick the lowest start above the query start, then bound it by the query end
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      is_lowest = above[i];
      for (int j = 0; j < NUM_ENTRIES; j++) begin
        if (j != i && above[j] && !less[i][j]) begin
          is_lowest = 1'b0;
        end
      end
      lowest_ok[i] = is_lowest && (lo[i] <= item.hi_addr);
    end
  end

  // Lowest free slot
  always_comb begin
    free_slot = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_slot = idx_t'(i);
      end
    end
  end

  // Select the returned entry per command
  always_comb begin
    case (item.cmd)
      CMD_SEARCH:  sel = contain;
      CMD_OVERLAP: sel = (|contain) ? contain : lowest_ok;
      default:     sel = '0;
    endcase
  end

  // One-hot OR mux of the returned entry
  always_comb begin
    sel_tag = '0;
    sel_lo  = '0;
    sel_hi  = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (sel[i]) begin
        sel_tag = sel_tag | tag[i];
        sel_lo  = sel_lo  | lo[i];
        sel_hi  = sel_hi  | hi[i];
      end
    end
  end

  // Form the result and any table write
  always_comb begin
    result.hit      = |sel;
    result.tag_out  = sel_tag;
    result.match_lo = sel_lo;
    result.match_hi = sel_hi;
    wr_req.en       = 1'b0;
    wr_req.slot     = free_slot;
    wr_req.lo       = item.lo_addr;
    wr_req.hi       = item.hi_addr;
    wr_req.tag      = item.tag_in;
    case (item.cmd)
      CMD_INSERT: begin
        if (item.lo_addr > item.hi_addr) begin
          result.status = ST_INVALID;
        end else if (|overlap) begin
          result.status = ST_BUSY;
        end else if (&valid) begin
          result.status = ST_FULL;
        end else begin
          result.status = ST_OK;
          wr_req.en     = 1'b1;
        end
      end
      CMD_SEARCH, CMD_OVERLAP: begin
        result.status = (|sel) ? ST_OK : ST_NOT_FOUND;
      end
      default: begin
        result.status = ST_NOT_FOUND;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/address_range_table_core.sv]
// ----------------------------------------------------------------------------
// address_range_table_core
// Bounded table of non-overlapping inclusive address ranges with insert,
// point search and first-overlap query.
// ----------------------------------------------------------------------------
// The block takes one command per clock while the output is not stalled and
// returns exactly one result per command. A command is held in the input
// register, then resolved in a single pass into the result register. Every
// entry is compared in parallel, and the lowest start above a query start is
// read from a pairwise start-order matrix that is refreshed on each insert, so
// no command needs more than one pass. An insert updates the table as its
// result is registered, and the very next command sees it. There is no clearing
// pass: reset clears the valid bits at once.
`timescale 1ns / 1ps
`default_nettype none

`include "address_range_table_core_assert.svh"

module address_range_table_core
  import art_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic      s1_valid_r;
  logic      s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;

  logic      out_free;
  logic      s1_adv;
  logic      in_fire;

  out_item_t result;
  tbl_wr_t   wr_req;
  tbl_wr_t   tbl_wr;

  logic [NUM_ENTRIES-1:0] valid;
  addr_t                  lo   [NUM_ENTRIES];
  addr_t                  hi   [NUM_ENTRIES];
  tag_t                   tag  [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] less [NUM_ENTRIES];

  // Handshake: advance when the result register is empty or draining
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_free ? 1'b0 : out_valid_r);
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture transaction payloads
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_item_r <= result;
    end
  end

  // Commit an insert only as its result is registered
  always_comb begin
    tbl_wr    = wr_req;
    tbl_wr.en = wr_req.en && s1_adv;
  end

  art_table u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (tbl_wr),
    .valid (valid),
    .lo    (lo),
    .hi    (hi),
    .tag   (tag),
    .less  (less)
  );

  art_match u_match (
    .item   (s1_item_r),
    .valid  (valid),
    .lo     (lo),
    .hi     (hi),
    .tag    (tag),
    .less   (less),
    .result (result),
    .wr_req (wr_req)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // A returned range is always reported as success
  `ART_ASSERT_IMPL(a_hit_ok, out_valid_r && out_item_r.hit, out_item_r.status == ST_OK)
  // Without a returned range the range fields are clear
  `ART_ASSERT_IMPL(a_miss_zero, out_valid_r && !out_item_r.hit,
                   out_item_r.tag_out == '0 && out_item_r.match_lo == '0 &&
                   out_item_r.match_hi == '0)
  // A returned range is well formed
  `ART_ASSERT_IMPL(a_hit_order, out_valid_r && out_item_r.hit,
                   out_item_r.match_lo <= out_item_r.match_hi)
  // A table write always lands as an ok insert result
  `ART_ASSERT_NEXT(a_wr_result, tbl_wr.en,
                   out_valid_r && out_item_r.status == ST_OK && !out_item_r.hit)
  // A stored range never overlaps another, so at most one entry holds an address
  `ART_ASSERT_IMPL(a_one_contain, s1_valid_r && s1_item_r.cmd == CMD_SEARCH,
                   $onehot0(u_match.contain) && !(tbl_wr.en))

endmodule

`default_nettype wire

[dv/tb_address_range_table_core.sv]
// ----------------------------------------------------------------------------
// tb_address_range_table_core
// Self-checking bench for the address range table. Commands are driven on a
// valid/stall channel and mirrored into an in-bench copy of the range table,
// which works out the answer due for each accepted transaction. Every answer
// that leaves the block is compared field by field, in order. A directed run
// covers empty and boundary cases first. Random commands then follow, aimed
// at stored range edges, under three idling patterns on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_address_range_table_core
  import art_pkg::*;
();

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam addr_t      ADDR_MAX     = {ADDR_BITS{1'b1}};
  localparam addr_t      ADDR_ONE     = addr_t'(1);
  localparam int         RANDOM_ITEMS = 400;
  localparam int         QUIET_LIMIT  = 2000;
  localparam int         DRAIN_CYCLES = 8;
  localparam int         MAX_REPORTS  = 10;

  // Mirror of the range table plus the answers still owed by the block
  class range_table_checker;
    bit        occupied  [NUM_ENTRIES];
    addr_t     range_lo  [NUM_ENTRIES];
    addr_t     range_hi  [NUM_ENTRIES];
    tag_t      range_tag [NUM_ENTRIES];
    out_item_t owed_answers [$];
    int        mismatches;

    function int slot_holding(addr_t a);
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (occupied[i] && range_lo[i] <= a && a <= range_hi[i]) return i;
      end
      return -1;
    endfunction

    // Malformed first, then overlap, then full; otherwise take the lowest free slot
    function logic [2:0] store_range(addr_t lo, addr_t hi, tag_t tag);
      int free_slot;
      free_slot = -1;
      if (lo > hi) return ST_INVALID;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (occupied[i]) begin
          if (hi >= range_lo[i] && range_hi[i] >= lo) return ST_BUSY;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (free_slot < 0) return ST_FULL;
      occupied[free_slot]  = 1'b1;
      range_lo[free_slot]  = lo;
      range_hi[free_slot]  = hi;
      range_tag[free_slot] = tag;
      return ST_OK;
    endfunction

    // Containing range wins; else the lowest start above lo, if it is no later than hi
    function int first_overlap_slot(addr_t lo, addr_t hi);
      int best;
      best = slot_holding(lo);
      if (best >= 0) return best;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (occupied[i] && range_lo[i] > lo && (best < 0 || range_lo[i] < range_lo[best]))
          best = i;
      end
      if (best >= 0 && range_lo[best] <= hi) return best;
      return -1;
    endfunction

    function int random_slot();
      int used [$];
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (occupied[i]) used.push_back(i);
      end
      if (used.size() == 0) return -1;
      return used[$urandom_range(used.size() - 1)];
    endfunction

    // Apply an accepted command to the mirror and queue the answer it owes
    function void note_command(in_item_t item);
      out_item_t answer;
      int        slot;
      answer = '0;
      slot   = -1;
      case (item.cmd)
        CMD_INSERT: begin
          answer.status = store_range(item.lo_addr, item.hi_addr, item.tag_in);
        end
        CMD_SEARCH: begin
          slot          = slot_holding(item.lo_addr);
          answer.status = (slot >= 0) ? ST_OK : ST_NOT_FOUND;
        end
        CMD_OVERLAP: begin
          slot          = first_overlap_slot(item.lo_addr, item.hi_addr);
          answer.status = (slot >= 0) ? ST_OK : ST_NOT_FOUND;
        end
        default: begin
          answer.status = ST_NOT_FOUND;
        end
      endcase
      if (slot >= 0) begin
        answer.hit      = 1'b1;
        answer.tag_out  = range_tag[slot];
        answer.match_lo = range_lo[slot];
        answer.match_hi = range_hi[slot];
      end
      owed_answers.push_back(answer);
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
      end
    endfunction

    // Match a delivered answer against the oldest one owed
    function void check_answer(out_item_t got);
      out_item_t want;
      if (owed_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected answer: status %0d hit %0d", got.status, got.hit);
        return;
      end
      want = owed_answers.pop_front();
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("hit", 64'(want.hit), 64'(got.hit));
      compare_field("tag_out", 64'(want.tag_out), 64'(got.tag_out));
      compare_field("match_lo", 64'(want.match_lo), 64'(got.match_lo));
      compare_field("match_hi", 64'(want.match_hi), 64'(got.match_hi));
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int quiet_cycles   = 0;

  range_table_checker table_mirror;

  address_range_table_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Stall the answer channel at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // Score both channels and end the run if the block goes quiet for too long
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) table_mirror.note_command(in_data);
    if (rst_n && out_valid && !out_stall) table_mirror.check_answer(out_data);
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_address_range_table_core NOT OK");
      $finish;
    end
  end

  // Random idling on the command side, then hold the transaction until taken
  task automatic send_item(input in_item_t item);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_cmd(input logic [1:0] cmd, input addr_t lo, input addr_t hi,
                          input tag_t tag);
    in_item_t item;
    item.cmd     = cmd;
    item.lo_addr = lo;
    item.hi_addr = hi;
    item.tag_in  = tag;
    send_item(item);
  endtask

  // Addresses: full random, stored range edges, extremes, or a few dense clusters
  function automatic addr_t pick_addr();
    int slot;
    case ($urandom_range(3))
      0: begin
        return addr_t'({$urandom(), $urandom()});
      end
      1: begin
        slot = table_mirror.random_slot();
        if (slot < 0) return addr_t'($urandom_range(8191));
        case ($urandom_range(4))
          0: return table_mirror.range_lo[slot] - ADDR_ONE;
          1: return table_mirror.range_lo[slot];
          2: return table_mirror.range_hi[slot];
          3: return table_mirror.range_hi[slot] + ADDR_ONE;
          default: return table_mirror.range_lo[slot] +
                          ((table_mirror.range_hi[slot] - table_mirror.range_lo[slot]) >> 1);
        endcase
      end
      2: begin
        case ($urandom_range(3))
          0: return '0;
          1: return ADDR_ONE;
          2: return ADDR_MAX - ADDR_ONE;
          default: return ADDR_MAX;
        endcase
      end
      default: begin
        return (addr_t'($urandom_range(3)) << (ADDR_BITS - 2)) |
               addr_t'($urandom_range(65535));
      end
    endcase
    return '0;
  endfunction

  function automatic addr_t pick_span();
    case ($urandom_range(9))
      0: return addr_t'({$urandom(), $urandom()});
      1: return ADDR_MAX;
      2, 3: return addr_t'($urandom_range(65535));
      default: return addr_t'($urandom_range(255));
    endcase
    return '0;
  endfunction

  function automatic in_item_t random_item();
    in_item_t item;
    int       pick;
    pick         = $urandom_range(99);
    item.tag_in  = tag_t'($urandom());
    item.lo_addr = pick_addr();
    item.hi_addr = item.lo_addr + pick_span();
    // clamp a wrapped end to the top of the address space
    if (item.hi_addr < item.lo_addr) item.hi_addr = ADDR_MAX;
    if (pick < 30)
      item.cmd = CMD_INSERT;
    else if (pick < 62)
      item.cmd = CMD_SEARCH;
    else if (pick < 95)
      item.cmd = CMD_OVERLAP;
    else
      item.cmd = CMD_UNUSED;
    // search ignores the end, so let it carry anything
    if (item.cmd == CMD_SEARCH)
      item.hi_addr = pick_addr();
    else if ($urandom_range(9) == 0)
      item.hi_addr = item.lo_addr - ADDR_ONE - addr_t'($urandom_range(255));
    return item;
  endfunction

  initial begin
    table_mirror   = new;
    src_idle_pct   = 11;
    sink_stall_pct = 76;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, unused command and a malformed insert
    send_cmd(CMD_SEARCH, '0, '0, '0);
    send_cmd(CMD_OVERLAP, '0, ADDR_MAX, '0);
    send_cmd(CMD_UNUSED, ADDR_MAX, ADDR_MAX, '1);
    send_cmd(CMD_INSERT, ADDR_MAX, '0, 16'h5a5a);
    // Ranges at both ends of the address space and one in between
    send_cmd(CMD_INSERT, '0, '0, '1);
    send_cmd(CMD_INSERT, ADDR_MAX, ADDR_MAX, '0);
    send_cmd(CMD_INSERT, 48'h1000, 48'h1fff, 16'h1234);
    send_cmd(CMD_INSERT, 48'h1fff, 48'h2fff, 16'h4321);
    // malformed and overlapping: malformed must win
    send_cmd(CMD_INSERT, 48'h1800, 48'h1400, 16'h7777);
    send_cmd(CMD_INSERT, 48'h2000, 48'h2000, 16'haaaa);
    send_cmd(CMD_SEARCH, '0, ADDR_MAX, '0);
    send_cmd(CMD_SEARCH, ADDR_MAX, '0, '0);
    send_cmd(CMD_SEARCH, 48'h1fff, '0, '0);
    send_cmd(CMD_SEARCH, 48'h2001, '0, '0);
    send_cmd(CMD_SEARCH, ADDR_MAX - ADDR_ONE, '0, '0);
    // First overlap: end on a start, end one short, start above end
    send_cmd(CMD_OVERLAP, 48'h0800, 48'h1000, '0);
    send_cmd(CMD_OVERLAP, 48'h0800, 48'h0fff, '0);
    send_cmd(CMD_OVERLAP, 48'h1800, 48'h0100, '0);
    send_cmd(CMD_OVERLAP, 48'h2001, 48'h1000, '0);
    send_cmd(CMD_OVERLAP, 48'h0001, ADDR_MAX, '0);
    send_cmd(CMD_OVERLAP, ADDR_MAX - ADDR_ONE, ADDR_MAX, '0);
    send_cmd(CMD_UNUSED, '0, '0, '0);

    // Random commands under three idling patterns
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        src_idle_pct   = 76;
        sink_stall_pct = 11;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
      send_item(random_item());
    end
    in_valid <= 1'b0;

    // Drain, then allow for any stray answer
    while (table_mirror.owed_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (table_mirror.mismatches == 0 && table_mirror.owed_answers.size() == 0)
      $display("tb_address_range_table_core OK");
    else
      $display("tb_address_range_table_core NOT OK");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/art_pkg.sv
rtl/core/art_table.sv
rtl/core/art_match.sv
rtl/core/address_range_table_core.sv
dv/tb_address_range_table_core.sv
